// ----- sv/ird_pkg.sv -----
// ----------------------------------------------------------------------------
// ird_pkg
// Shared types and constants of the interleaved request deframer.
// ----------------------------------------------------------------------------
package ird_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned LenW     = 12;
  localparam int unsigned PayLenW  = 16;

  localparam logic [ByteW-1:0] ChDollar = 8'h24;
  localparam logic [ByteW-1:0] ChCr     = 8'h0D;
  localparam logic [ByteW-1:0] ChLf     = 8'h0A;

  localparam logic [LenW-1:0] MaxLenReset = 12'd2047;

  // Header bytes after the '$' marker: channel, length high, length low.
  localparam logic [1:0] HdrChannel = 2'd0;
  localparam logic [1:0] HdrLenHigh = 2'd1;
  localparam logic [1:0] HdrLenLow  = 2'd2;

  // Progress through CR LF CR LF.
  localparam logic [1:0] TermNone  = 2'd0;
  localparam logic [1:0] TermCr    = 2'd1;
  localparam logic [1:0] TermCrLf  = 2'd2;
  localparam logic [1:0] TermCrLfCr = 2'd3;

  typedef enum logic [2:0] {
    ModeIdle         = 3'd0,
    ModeFrameHeader  = 3'd1,
    ModeFramePayload = 3'd2,
    ModeRequest      = 3'd3,
    ModeError        = 3'd4
  } parse_mode_e;

  typedef struct packed {
    logic             valid;
    logic [ByteW-1:0] req_byte;
    logic             req_last;
    logic             overflow_error;
  } result_t;

endpackage

// ----- sv/interleaved_request_deframer.sv -----
// ----------------------------------------------------------------------------
// interleaved_request_deframer
// Splits a received RTSP-over-TCP byte stream into text requests and drops
// interleaved binary frames.
// ----------------------------------------------------------------------------
// One byte is taken every cycle when the output side keeps up. A byte is
// caught in an input register and parsed from there; its request byte (if
// any) is loaded into the result register when the parser steps, which
// happens only while the result register is empty or being read. The
// parser updates its state once per byte, which sets the rate of one byte
// per cycle. Binary frames, stray CR/LF bytes between messages, and all
// bytes after an overflow give no output.
// An overflow raises tuser with tdata zero and blocks the connection until
// a byte arrives with conn_start set. max_request_len is written on cfg_we_i
// and must only change while the block is idle.
module interleaved_request_deframer (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [11:0]               cfg_wdata_i,     // max_request_len
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [7:0]                s_axis_tdata,    // [7:0] rx_byte
  input  logic                      s_axis_tuser,    // [0] conn_start
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [7:0]                m_axis_tdata,    // [7:0] req_byte
  output logic                      m_axis_tlast,    // req_last
  output logic                      m_axis_tuser     // [0] overflow_error
);

  logic [ird_pkg::LenW-1:0]  max_len_q;
  logic                      in_valid_q;
  logic [ird_pkg::ByteW-1:0] in_byte_q;
  logic                      in_start_q;
  logic                      out_valid_q;
  logic [ird_pkg::ByteW-1:0] out_byte_q;
  logic                      out_last_q;
  logic                      out_err_q;
  logic                      advance;
  ird_pkg::result_t          result;

  // The parser steps whenever the result register can take what it yields.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  ird_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .rx_byte_i    (in_byte_q),
    .conn_start_i (in_start_q),
    .max_len_i    (max_len_q),
    .result_o     (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q   <= ird_pkg::MaxLenReset;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_len_q <= cfg_wdata_i;
      end
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= result.valid;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q  <= s_axis_tdata;
      in_start_q <= s_axis_tuser;
    end
    if (advance && result.valid) begin
      out_byte_q <= result.req_byte;
      out_last_q <= result.req_last;
      out_err_q  <= result.overflow_error;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_err_q;

endmodule

// ----- sv/ird_parser.sv -----
// ----------------------------------------------------------------------------
// ird_parser
// Parser state and per-byte decision: skips framing bytes, discards
// interleaved binary frames and passes text request bytes on.
// ----------------------------------------------------------------------------
module ird_parser (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           step_i,
  input  logic [ird_pkg::ByteW-1:0]      rx_byte_i,
  input  logic                           conn_start_i,
  input  logic [ird_pkg::LenW-1:0]       max_len_i,
  output ird_pkg::result_t               result_o
);

  ird_pkg::parse_mode_e           mode_q, mode_d, mode_c;
  logic [1:0]                     hdr_idx_q, hdr_idx_d, hdr_idx_c;
  logic [ird_pkg::ByteW-1:0]      len_high_q, len_high_d, len_high_c;
  logic [ird_pkg::PayLenW-1:0]    remain_q, remain_d, remain_c;
  logic [ird_pkg::LenW-1:0]       count_q, count_d, count_c;
  logic [1:0]                     term_q, term_d, term_c;
  logic [ird_pkg::LenW:0]         count_inc;
  logic [ird_pkg::PayLenW-1:0]    remain_dec;
  logic                           is_cr, is_lf;

  assign is_cr = (rx_byte_i == ird_pkg::ChCr);
  assign is_lf = (rx_byte_i == ird_pkg::ChLf);

  always_comb begin
    // A connection restart clears the parser before this byte is handled.
    if (conn_start_i) begin
      mode_c     = ird_pkg::ModeIdle;
      hdr_idx_c  = '0;
      len_high_c = '0;
      remain_c   = '0;
      count_c    = '0;
      term_c     = ird_pkg::TermNone;
    end else begin
      mode_c     = mode_q;
      hdr_idx_c  = hdr_idx_q;
      len_high_c = len_high_q;
      remain_c   = remain_q;
      count_c    = count_q;
      term_c     = term_q;
    end

    mode_d     = mode_c;
    hdr_idx_d  = hdr_idx_c;
    len_high_d = len_high_c;
    remain_d   = remain_c;
    count_d    = count_c;
    term_d     = term_c;
    result_o   = '0;

    // The first byte of a request starts from a zero count.
    if (mode_c == ird_pkg::ModeIdle) begin
      count_inc = {{ird_pkg::LenW{1'b0}}, 1'b1};
    end else begin
      count_inc = {1'b0, count_c} + {{ird_pkg::LenW{1'b0}}, 1'b1};
    end
    remain_dec = (remain_c != '0) ? remain_c - 1'b1 : remain_c;

    case (mode_c)
      ird_pkg::ModeFrameHeader: begin
        if (hdr_idx_c == ird_pkg::HdrChannel) begin
          hdr_idx_d = ird_pkg::HdrLenHigh;
        end else if (hdr_idx_c == ird_pkg::HdrLenHigh) begin
          len_high_d = rx_byte_i;
          hdr_idx_d  = ird_pkg::HdrLenLow;
        end else begin
          remain_d  = {len_high_c, rx_byte_i};
          hdr_idx_d = '0;
          mode_d    = ({len_high_c, rx_byte_i} == '0) ? ird_pkg::ModeIdle
                                                      : ird_pkg::ModeFramePayload;
        end
      end
      ird_pkg::ModeFramePayload: begin
        remain_d = remain_dec;
        if (remain_dec == '0) begin
          mode_d = ird_pkg::ModeIdle;
        end
      end
      ird_pkg::ModeIdle, ird_pkg::ModeRequest: begin
        if (mode_c == ird_pkg::ModeIdle && (is_cr || is_lf)) begin
          // Stray line endings between messages are dropped.
        end else if (mode_c == ird_pkg::ModeIdle && rx_byte_i == ird_pkg::ChDollar) begin
          mode_d     = ird_pkg::ModeFrameHeader;
          hdr_idx_d  = '0;
          len_high_d = '0;
          remain_d   = '0;
        end else if (count_inc > {1'b0, max_len_i}) begin
          mode_d                  = ird_pkg::ModeError;
          count_d                 = '0;
          term_d                  = ird_pkg::TermNone;
          result_o.valid          = 1'b1;
          result_o.overflow_error = 1'b1;
        end else begin
          mode_d            = ird_pkg::ModeRequest;
          count_d           = count_inc[ird_pkg::LenW-1:0];
          result_o.valid    = 1'b1;
          result_o.req_byte = rx_byte_i;
          if (mode_c == ird_pkg::ModeIdle) begin
            term_d = ird_pkg::TermNone;
          end
          if (is_cr) begin
            term_d = (mode_c == ird_pkg::ModeRequest && term_c == ird_pkg::TermCrLf)
                     ? ird_pkg::TermCrLfCr : ird_pkg::TermCr;
          end else if (is_lf && mode_c == ird_pkg::ModeRequest) begin
            if (term_c == ird_pkg::TermCr) begin
              term_d = ird_pkg::TermCrLf;
            end else if (term_c == ird_pkg::TermCrLfCr) begin
              result_o.req_last = 1'b1;
              mode_d            = ird_pkg::ModeIdle;
              count_d           = '0;
              term_d            = ird_pkg::TermNone;
            end else begin
              term_d = ird_pkg::TermNone;
            end
          end else begin
            term_d = ird_pkg::TermNone;
          end
        end
      end
      default: begin
        mode_d = ird_pkg::ModeError;
      end
    endcase

    if (!step_i) begin
      result_o = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= ird_pkg::ModeIdle;
      hdr_idx_q  <= '0;
      len_high_q <= '0;
      remain_q   <= '0;
      count_q    <= '0;
      term_q     <= ird_pkg::TermNone;
    end else if (step_i) begin
      mode_q     <= mode_d;
      hdr_idx_q  <= hdr_idx_d;
      len_high_q <= len_high_d;
      remain_q   <= remain_d;
      count_q    <= count_d;
      term_q     <= term_d;
    end
  end

endmodule

// ----- test/interleaved_request_deframer_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interleaved_request_deframer_test
// Drives RTSP-over-TCP byte streams into the deframer and checks every
// request byte, end flag and overflow against a cycle-free predictor or typed results.
// ----------------------------------------------------------------------------
module interleaved_request_deframer_test;

  localparam int unsigned PhaseItems  = 215;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned StallLimit  = 2000;

  localparam ird_pkg::result_t NoResult       = '0;
  localparam ird_pkg::result_t OverflowResult = '{1'b1, 8'h00, 1'b0, 1'b1};

  typedef enum logic [1:0] {RowPredict, RowTyped, RowConfig} row_kind_e;

  typedef enum logic [1:0] {MsgRequest, MsgFrame, MsgStray, MsgNoise} msg_kind_e;

  typedef struct packed {
    row_kind_e        kind;
    logic [11:0]      value;   // rx_byte in the low bits, or max_request_len
    logic             start;
    ird_pkg::result_t typed;
  } stim_row_t;

  localparam stim_row_t DirectedRows [24] = '{
    '{RowTyped,   12'h00D, 1'b1, NoResult},                      // stray CR
    '{RowTyped,   12'h00A, 1'b0, NoResult},                      // stray LF
    '{RowTyped,   12'h024, 1'b0, NoResult},
    '{RowTyped,   12'h0FF, 1'b0, NoResult},
    '{RowTyped,   12'h000, 1'b0, NoResult},
    '{RowTyped,   12'h000, 1'b0, NoResult},                      // empty frame
    '{RowPredict, 12'h024, 1'b0, NoResult},
    '{RowPredict, 12'h000, 1'b0, NoResult},
    '{RowPredict, 12'h000, 1'b0, NoResult},
    '{RowPredict, 12'h002, 1'b0, NoResult},
    '{RowPredict, 12'h0FF, 1'b0, NoResult},
    '{RowPredict, 12'h024, 1'b0, NoResult},
    '{RowPredict, 12'h024, 1'b0, NoResult},
    '{RowPredict, 12'h052, 1'b1, NoResult},                      // restart in header
    '{RowTyped,   12'h0FF, 1'b0, '{1'b1, 8'hFF, 1'b0, 1'b0}},
    '{RowTyped,   12'h000, 1'b0, '{1'b1, 8'h00, 1'b0, 1'b0}},
    '{RowPredict, 12'h00D, 1'b0, NoResult},
    '{RowPredict, 12'h00A, 1'b0, NoResult},
    '{RowPredict, 12'h00D, 1'b0, NoResult},
    '{RowTyped,   12'h00A, 1'b0, '{1'b1, 8'h0A, 1'b1, 1'b0}},
    '{RowConfig,  12'd0,   1'b0, NoResult},
    '{RowTyped,   12'h041, 1'b0, OverflowResult},
    '{RowTyped,   12'h041, 1'b0, NoResult},                      // dropped in error
    '{RowTyped,   12'h00D, 1'b1, NoResult}
  };

  localparam logic [11:0] PhaseLimits [6] = '{
    12'd16, 12'd4095, 12'd60, 12'd200, 12'd16, 12'd1000
  };

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [11:0] cfg_wdata_i   = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;
  logic        s_axis_tuser  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;

  // Predictor state.
  ird_pkg::parse_mode_e mode;
  logic [1:0]  hdr_idx;
  logic [7:0]  len_hi;
  logic [15:0] pay_left;
  logic [11:0] req_count;
  logic [1:0]  term;
  logic [11:0] max_len;

  ird_pkg::result_t expected_req_q[$];
  int unsigned fail_count    = 0;
  int unsigned items_counted = 0;
  int unsigned quiet_cycles  = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  interleaved_request_deframer uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #2 clk_i = ~clk_i;

  function automatic void clear_parser();
    mode      = ird_pkg::ModeIdle;
    hdr_idx   = ird_pkg::HdrChannel;
    len_hi    = '0;
    pay_left  = '0;
    req_count = '0;
    term      = ird_pkg::TermNone;
  endfunction

  // Advances the parser by one byte and returns the request byte it yields.
  function automatic ird_pkg::result_t deframe_byte(input logic [7:0] b, input logic st);
    ird_pkg::result_t r;
    logic        in_req;
    logic        last;
    logic [12:0] next_count;
    r      = NoResult;
    in_req = 1'b0;
    last   = 1'b0;
    if (st) clear_parser();
    case (mode)
      ird_pkg::ModeIdle: begin
        if (b == ird_pkg::ChDollar) begin
          mode     = ird_pkg::ModeFrameHeader;
          hdr_idx  = ird_pkg::HdrChannel;
          len_hi   = '0;
          pay_left = '0;
        end else if (b != ird_pkg::ChCr && b != ird_pkg::ChLf) begin
          mode      = ird_pkg::ModeRequest;
          req_count = '0;
          term      = ird_pkg::TermNone;
          in_req    = 1'b1;
        end
      end
      ird_pkg::ModeFrameHeader: begin
        if (hdr_idx == ird_pkg::HdrChannel) begin
          hdr_idx = ird_pkg::HdrLenHigh;
        end else if (hdr_idx == ird_pkg::HdrLenHigh) begin
          len_hi  = b;
          hdr_idx = ird_pkg::HdrLenLow;
        end else begin
          pay_left = {len_hi, b};
          hdr_idx  = ird_pkg::HdrChannel;
          mode     = (pay_left == '0) ? ird_pkg::ModeIdle : ird_pkg::ModeFramePayload;
        end
      end
      ird_pkg::ModeFramePayload: begin
        if (pay_left != '0) pay_left = pay_left - 16'd1;
        if (pay_left == '0) mode = ird_pkg::ModeIdle;
      end
      ird_pkg::ModeRequest: in_req = 1'b1;
      default: mode = ird_pkg::ModeError;
    endcase
    if (in_req) begin
      next_count = {1'b0, req_count} + 13'd1;
      if (next_count > {1'b0, max_len}) begin
        mode      = ird_pkg::ModeError;
        req_count = '0;
        term      = ird_pkg::TermNone;
        r         = OverflowResult;
      end else begin
        req_count = next_count[11:0];
        if (b == ird_pkg::ChCr) begin
          term = (term == ird_pkg::TermCrLf) ? ird_pkg::TermCrLfCr : ird_pkg::TermCr;
        end else if (b == ird_pkg::ChLf) begin
          if (term == ird_pkg::TermCr) term = ird_pkg::TermCrLf;
          else if (term == ird_pkg::TermCrLfCr) last = 1'b1;
          else term = ird_pkg::TermNone;
        end else begin
          term = ird_pkg::TermNone;
        end
        r = '{1'b1, b, last, 1'b0};
        if (last) begin
          mode      = ird_pkg::ModeIdle;
          req_count = '0;
          term      = ird_pkg::TermNone;
        end
      end
    end
    return r;
  endfunction

  task automatic send_rx_byte(input logic [7:0] b, input logic st, input logic use_typed,
                              input ird_pkg::result_t typed);
    ird_pkg::result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= st;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    r = deframe_byte(b, st);
    if (use_typed) r = typed;
    if (r.valid) expected_req_q.push_back(r);
  endtask

  // Waits until every expected request byte is out and the pipeline is empty.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_req_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_max_len(input logic [11:0] v);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    max_len      = v;
  endtask

  // Builds one message (or a broken piece of one) and sends it.
  task automatic send_message(input logic big_frame);
    logic [7:0]  msg_bytes[$];
    logic        msg_start[$];
    msg_kind_e   kind;
    int unsigned pick;
    int unsigned len;
    int unsigned pay_len;
    int unsigned cut;
    logic [7:0]  b;
    pick = $urandom_range(19);
    if (big_frame) kind = MsgFrame;
    else if (pick < 10) kind = MsgRequest;
    else if (pick < 15) kind = MsgFrame;
    else if (pick < 17) kind = MsgStray;
    else kind = MsgNoise;

    case (kind)
      MsgRequest: begin
        if (max_len <= 12'd300 && $urandom_range(5) == 0)
          len = max_len - 1 + $urandom_range(2);
        else
          len = 5 + $urandom_range(35);
        do b = 8'($urandom_range(255));
        while (b == ird_pkg::ChCr || b == ird_pkg::ChLf || b == ird_pkg::ChDollar);
        msg_bytes.push_back(b);
        repeat (len - 5) begin
          pick = $urandom_range(7);
          msg_bytes.push_back(pick == 0 ? ird_pkg::ChCr :
                              pick == 1 ? ird_pkg::ChLf : 8'($urandom_range(255)));
        end
        msg_bytes.push_back(ird_pkg::ChCr);
        msg_bytes.push_back(ird_pkg::ChLf);
        msg_bytes.push_back(ird_pkg::ChCr);
        msg_bytes.push_back(ird_pkg::ChLf);
      end
      MsgFrame: begin
        // The longest frame is only started; a restart usually cuts it short.
        if (big_frame) begin
          len     = 16'hFFFF;
          pay_len = 8;
        end else begin
          if ($urandom_range(15) == 0) len = $urandom_range(600);
          else len = $urandom_range(24);
          pay_len = len;
        end
        msg_bytes.push_back(ird_pkg::ChDollar);
        msg_bytes.push_back(8'($urandom_range(255)));
        msg_bytes.push_back(8'(len >> 8));
        msg_bytes.push_back(8'(len));
        repeat (pay_len) msg_bytes.push_back(8'($urandom_range(255)));
      end
      MsgStray: begin
        repeat (1 + $urandom_range(2))
          msg_bytes.push_back($urandom_range(1) ? ird_pkg::ChCr : ird_pkg::ChLf);
      end
      default: begin
        repeat (1 + $urandom_range(3)) msg_bytes.push_back(8'($urandom_range(255)));
      end
    endcase

    foreach (msg_bytes[i]) msg_start.push_back(kind == MsgNoise && $urandom_range(3) == 0);
    // A blocked connection, or one deep in a long frame, is usually restarted soon.
    if (mode == ird_pkg::ModeError ||
        (mode == ird_pkg::ModeFramePayload && pay_left > 16'd1000))
      msg_start[0] = ($urandom_range(9) < 8);
    else if (kind != MsgNoise) msg_start[0] = ($urandom_range(9) == 0);

    cut = msg_bytes.size();
    if (!big_frame && kind != MsgNoise && $urandom_range(9) == 0)
      cut = 1 + $urandom_range(msg_bytes.size() - 1);

    for (int i = 0; i < cut; i++) begin
      send_rx_byte(msg_bytes[i], msg_start[i], 1'b0, NoResult);
      items_counted++;
    end
  endtask

  // Receiver: random back-pressure, result checking and the stall watchdog.
  always @(posedge clk_i) begin
    ird_pkg::result_t exp_r;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_req_q.size() == 0) begin
          $display("%0t: unexpected request byte data=%h last=%b overflow=%b",
                   $time, m_axis_tdata, m_axis_tlast, m_axis_tuser);
          fail_count++;
        end else begin
          exp_r = expected_req_q.pop_front();
          if (m_axis_tdata !== exp_r.req_byte) begin
            $display("%0t: req_byte expected %h actual %h", $time, exp_r.req_byte, m_axis_tdata);
            fail_count++;
          end
          if (m_axis_tlast !== exp_r.req_last) begin
            $display("%0t: req_last expected %b actual %b", $time, exp_r.req_last, m_axis_tlast);
            fail_count++;
          end
          if (m_axis_tuser !== exp_r.overflow_error) begin
            $display("%0t: overflow_error expected %b actual %b",
                     $time, exp_r.overflow_error, m_axis_tuser);
            fail_count++;
          end
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == StallLimit) begin
        $display("%0t: no handshake for %0d cycles", $time, StallLimit);
        $display("interleaved_request_deframer test failed");
        $finish;
      end
    end
  end

  initial begin
    max_len = ird_pkg::MaxLenReset;
    clear_parser();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirectedRows[i]) begin
      if (DirectedRows[i].kind == RowConfig)
        write_max_len(DirectedRows[i].value);
      else
        send_rx_byte(DirectedRows[i].value[7:0], DirectedRows[i].start,
                     DirectedRows[i].kind == RowTyped, DirectedRows[i].typed);
    end

    // Pairs of phases: receiver mostly idle, then sender mostly idle, then no gaps.
    foreach (PhaseLimits[p]) begin
      write_max_len(PhaseLimits[p]);
      send_idle_pct = (p < 2) ? 33 : (p < 4) ? 53 : 0;
      recv_idle_pct = (p < 2) ? 53 : (p < 4) ? 33 : 0;
      items_counted = 0;
      if (p == 4) send_message(1'b1);
      while (items_counted < PhaseItems) send_message(1'b0);
    end

    wait_drained();
    if (fail_count == 0) begin
      $display("interleaved_request_deframer test passed");
    end else begin
      $display("interleaved_request_deframer test failed");
    end
    $finish;
  end

endmodule
